// ----- src/ema_peak_hold_meter_unit_macros.svh -----
// Assertion macros shared by the ema peak hold meter checks.
`ifndef EMA_PEAK_HOLD_METER_UNIT_MACROS_SVH
`define EMA_PEAK_HOLD_METER_UNIT_MACROS_SVH

// Same-cycle implication, skipped while rst is high.
`define EPHM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ema peak hold meter check failed");

// Next-cycle implication, skipped while rst is high.
`define EPHM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ema peak hold meter check failed");

`endif

// ----- src/ephm_pkg.sv -----
// Types and constants of the ema peak hold meter.
`default_nettype none

package ephm_pkg;

   localparam int EVENT_SUM_W = 16;
   localparam int WORK_SUM_W  = 32;
   localparam int ALPHA_W     = 16;
   localparam int HOLD_W      = 16;
   localparam int AMOUNT_W    = 16;
   localparam int AVG_WORK_W  = 40;
   localparam int AVG_EVENT_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [0:0] OP_RECORD    = 1'b0;
   localparam logic [0:0] OP_FRAME_END = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD  = 1'b1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd2149;
   localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd400;

   localparam logic [ALPHA_W-1:0] ROUND_HALF = 16'h8000;

   typedef struct packed {
      logic [EVENT_SUM_W-1:0] events_this_frame;
      logic [WORK_SUM_W-1:0]  work_this_frame;
      logic [AVG_WORK_W-1:0]  avg_work;
      logic [AVG_EVENT_W-1:0] avg_events;
      logic [AVG_WORK_W-1:0]  peak_work;
      logic [AVG_EVENT_W-1:0] peak_events;
      logic                   work_peak_expired;
      logic                   events_peak_expired;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/ema_peak_hold_meter_unit.sv -----
// Top level of the two-channel moving average meter with peak hold.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_op, req_work_amount
//   rsp      out        rsp_valid / rsp_ready   eight result fields, one word per req word
//   csr      in         csr_wr_en               csr_index, csr_wdata
//
// One word per cycle while req_ready is high; each result is registered.
// Throughput is set by the average update: subtract, 40x16 multiply, round and
// add, then the peak compare, all between the meter state and the result register.
// A two-word output buffer takes one more req word during an rsp stall;
// req_ready drops only while both buffer words are full.
// Synchronous reset clears sums, averages, peaks and hold counters; csrs load defaults.
`default_nettype none

module ema_peak_hold_meter_unit #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_wr_en,
   input  wire logic [ephm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [ephm_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic                                    req_valid,
   output      logic                                    req_ready,
   input  wire logic                                    req_op,
   input  wire logic [ephm_pkg::AMOUNT_W-1:0]           req_work_amount,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_ready,
   output      logic [ephm_pkg::EVENT_SUM_W-1:0]        rsp_events_this_frame,
   output      logic [ephm_pkg::WORK_SUM_W-1:0]         rsp_work_this_frame,
   output      logic [ephm_pkg::AVG_WORK_W-1:0]         rsp_avg_work,
   output      logic [ephm_pkg::AVG_EVENT_W-1:0]        rsp_avg_events,
   output      logic [ephm_pkg::AVG_WORK_W-1:0]         rsp_peak_work,
   output      logic [ephm_pkg::AVG_EVENT_W-1:0]        rsp_peak_events,
   output      logic                                    rsp_work_peak_expired,
   output      logic                                    rsp_events_peak_expired
);

   localparam int WA = ephm_pkg::WORK_SUM_W + FRAC_BITS;
   localparam int WE = ephm_pkg::EVENT_SUM_W + FRAC_BITS;
   localparam int PW = WA + ephm_pkg::ALPHA_W;
   localparam int HW = ephm_pkg::HOLD_W;

   typedef struct packed {
      logic [WA-1:0] peak;
      logic [HW-1:0] hold;
      logic          expired;
   } peak_type;

   function automatic logic [WA-1:0] ema_move(
      input logic [WA-1:0]                  avg,
      input logic [WA-1:0]                  target,
      input logic [ephm_pkg::ALPHA_W-1:0]   alpha
   );
      logic          up;
      logic [WA-1:0] diff;
      logic [PW-1:0] prod;
      logic [WA-1:0] step;
      up   = (target >= avg);
      diff = up ? (target - avg) : (avg - target);
      prod = PW'(diff) * PW'(alpha) + PW'(ephm_pkg::ROUND_HALF);
      step = prod[PW-1:ephm_pkg::ALPHA_W];
      return up ? (avg + step) : (avg - step);
   endfunction

   function automatic peak_type peak_step(
      input logic [WA-1:0] avg,
      input logic [WA-1:0] peak,
      input logic [HW-1:0] hold,
      input logic [HW-1:0] hold_frames
   );
      peak_type res;
      res.peak    = peak;
      res.hold    = hold;
      res.expired = 1'b0;
      priority if (avg > peak) begin
         res.peak = avg;
         res.hold = hold_frames;
      end else if (hold != '0) begin
         res.hold = hold - HW'(1);
         if (hold == HW'(1)) begin
            res.peak    = avg;
            res.expired = 1'b1;
         end
      end
      return res;
   endfunction

   logic [ephm_pkg::ALPHA_W-1:0]     alpha_ff, alpha_in;
   logic [HW-1:0]                    hold_frames_ff, hold_frames_in;
   logic [ephm_pkg::EVENT_SUM_W-1:0] event_sum_ff, event_sum_in;
   logic [ephm_pkg::WORK_SUM_W-1:0]  work_sum_ff, work_sum_in;
   logic [WA-1:0]                    work_avg_ff, work_avg_in;
   logic [WE-1:0]                    event_avg_ff, event_avg_in;
   logic [WA-1:0]                    work_peak_ff, work_peak_in;
   logic [WE-1:0]                    event_peak_ff, event_peak_in;
   logic [HW-1:0]                    work_hold_ff, work_hold_in;
   logic [HW-1:0]                    event_hold_ff, event_hold_in;
   logic                             main_valid_ff, main_valid_in;
   logic                             skid_valid_ff, skid_valid_in;
   ephm_pkg::rsp_type                main_ff, main_in;
   ephm_pkg::rsp_type                skid_ff, skid_in;

   logic                             accept;
   logic                             take;
   logic                             is_frame;
   logic [ephm_pkg::EVENT_SUM_W-1:0] rec_events;
   logic [ephm_pkg::WORK_SUM_W:0]    work_total;
   logic [ephm_pkg::WORK_SUM_W-1:0]  rec_work;
   logic [WA-1:0]                    work_avg_upd;
   logic [WA-1:0]                    event_avg_upd;
   peak_type                         work_pk;
   peak_type                         event_pk;
   ephm_pkg::rsp_type                rsp_new;

   assign req_ready = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = main_valid_ff && rsp_ready;
   assign is_frame  = (req_op == ephm_pkg::OP_FRAME_END);

   always_comb begin
      rec_events    = (event_sum_ff == '1) ? event_sum_ff
                                           : event_sum_ff + ephm_pkg::EVENT_SUM_W'(1);
      work_total    = {1'b0, work_sum_ff} + (ephm_pkg::WORK_SUM_W + 1)'(req_work_amount);
      rec_work      = work_total[ephm_pkg::WORK_SUM_W] ? '1
                                                       : work_total[ephm_pkg::WORK_SUM_W-1:0];
      work_avg_upd  = ema_move(work_avg_ff, WA'(work_sum_ff) << FRAC_BITS, alpha_ff);
      event_avg_upd = ema_move(WA'(event_avg_ff), WA'(event_sum_ff) << FRAC_BITS, alpha_ff);
      work_pk       = peak_step(work_avg_upd, work_peak_ff, work_hold_ff, hold_frames_ff);
      event_pk      = peak_step(event_avg_upd, WA'(event_peak_ff), event_hold_ff,
                                hold_frames_ff);
   end

   always_comb begin
      alpha_in       = alpha_ff;
      hold_frames_in = hold_frames_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ephm_pkg::CSR_ALPHA: begin
               alpha_in = csr_wdata;
            end
            ephm_pkg::CSR_HOLD: begin
               hold_frames_in = csr_wdata;
            end
            default: begin
               alpha_in = alpha_ff;
            end
         endcase
      end
   end

   always_comb begin
      event_sum_in  = event_sum_ff;
      work_sum_in   = work_sum_ff;
      work_avg_in   = work_avg_ff;
      event_avg_in  = event_avg_ff;
      work_peak_in  = work_peak_ff;
      event_peak_in = event_peak_ff;
      work_hold_in  = work_hold_ff;
      event_hold_in = event_hold_ff;
      if (accept) begin
         if (is_frame) begin
            event_sum_in  = '0;
            work_sum_in   = '0;
            work_avg_in   = work_avg_upd;
            event_avg_in  = WE'(event_avg_upd);
            work_peak_in  = work_pk.peak;
            event_peak_in = WE'(event_pk.peak);
            work_hold_in  = work_pk.hold;
            event_hold_in = event_pk.hold;
         end else begin
            event_sum_in = rec_events;
            work_sum_in  = rec_work;
         end
      end
   end

   always_comb begin
      if (is_frame) begin
         rsp_new.events_this_frame   = event_sum_ff;
         rsp_new.work_this_frame     = work_sum_ff;
         rsp_new.avg_work            = ephm_pkg::AVG_WORK_W'(work_avg_upd);
         rsp_new.avg_events          = ephm_pkg::AVG_EVENT_W'(event_avg_upd);
         rsp_new.peak_work           = ephm_pkg::AVG_WORK_W'(work_pk.peak);
         rsp_new.peak_events         = ephm_pkg::AVG_EVENT_W'(event_pk.peak);
         rsp_new.work_peak_expired   = work_pk.expired;
         rsp_new.events_peak_expired = event_pk.expired;
      end else begin
         rsp_new.events_this_frame   = rec_events;
         rsp_new.work_this_frame     = rec_work;
         rsp_new.avg_work            = ephm_pkg::AVG_WORK_W'(work_avg_ff);
         rsp_new.avg_events          = ephm_pkg::AVG_EVENT_W'(event_avg_ff);
         rsp_new.peak_work           = ephm_pkg::AVG_WORK_W'(work_peak_ff);
         rsp_new.peak_events         = ephm_pkg::AVG_EVENT_W'(event_peak_ff);
         rsp_new.work_peak_expired   = 1'b0;
         rsp_new.events_peak_expired = 1'b0;
      end
   end

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || take) begin
         priority if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in       = rsp_new;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff       <= ephm_pkg::ALPHA_RESET;
         hold_frames_ff <= ephm_pkg::HOLD_RESET;
         event_sum_ff   <= '0;
         work_sum_ff    <= '0;
         work_avg_ff    <= '0;
         event_avg_ff   <= '0;
         work_peak_ff   <= '0;
         event_peak_ff  <= '0;
         work_hold_ff   <= '0;
         event_hold_ff  <= '0;
         main_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         alpha_ff       <= alpha_in;
         hold_frames_ff <= hold_frames_in;
         event_sum_ff   <= event_sum_in;
         work_sum_ff    <= work_sum_in;
         work_avg_ff    <= work_avg_in;
         event_avg_ff   <= event_avg_in;
         work_peak_ff   <= work_peak_in;
         event_peak_ff  <= event_peak_in;
         work_hold_ff   <= work_hold_in;
         event_hold_ff  <= event_hold_in;
         main_valid_ff  <= main_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_events_this_frame   = main_ff.events_this_frame;
   assign rsp_work_this_frame     = main_ff.work_this_frame;
   assign rsp_avg_work            = main_ff.avg_work;
   assign rsp_avg_events          = main_ff.avg_events;
   assign rsp_peak_work           = main_ff.peak_work;
   assign rsp_peak_events         = main_ff.peak_events;
   assign rsp_work_peak_expired   = main_ff.work_peak_expired;
   assign rsp_events_peak_expired = main_ff.events_peak_expired;

endmodule

`default_nettype wire

// ----- src/ephm_checker.sv -----
// Port-level checks of the ema peak hold meter and their binding.
`default_nettype none
`include "ema_peak_hold_meter_unit_macros.svh"

module ephm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [ephm_pkg::EVENT_SUM_W-1:0]    rsp_events_this_frame,
   input wire logic [ephm_pkg::WORK_SUM_W-1:0]     rsp_work_this_frame,
   input wire logic [ephm_pkg::AVG_WORK_W-1:0]     rsp_avg_work,
   input wire logic [ephm_pkg::AVG_EVENT_W-1:0]    rsp_avg_events,
   input wire logic [ephm_pkg::AVG_WORK_W-1:0]     rsp_peak_work,
   input wire logic [ephm_pkg::AVG_EVENT_W-1:0]    rsp_peak_events,
   input wire logic                                rsp_work_peak_expired,
   input wire logic                                rsp_events_peak_expired
);

   logic req_taken;
   assign req_taken = req_valid && req_ready;

   // Drop every pending word on reset.
   `EPHM_ASSERT_NXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // Expiry drops the peak to the current average.
   `EPHM_ASSERT_IMP(a_work_expiry, clock, reset, rsp_valid && rsp_work_peak_expired,
                    rsp_peak_work == rsp_avg_work)
   `EPHM_ASSERT_IMP(a_events_expiry, clock, reset, rsp_valid && rsp_events_peak_expired,
                    rsp_peak_events == rsp_avg_events)

   // Hold a stalled word.
   `EPHM_ASSERT_NXT(a_rsp_hold, clock, reset, !reset && rsp_valid && !rsp_ready && !req_taken,
                    rsp_valid && $stable(rsp_events_this_frame)
                    && $stable(rsp_work_this_frame) && $stable(rsp_avg_work))

endmodule

bind ema_peak_hold_meter_unit ephm_checker u_ephm_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_ready               (req_ready),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_events_this_frame   (rsp_events_this_frame),
   .rsp_work_this_frame     (rsp_work_this_frame),
   .rsp_avg_work            (rsp_avg_work),
   .rsp_avg_events          (rsp_avg_events),
   .rsp_peak_work           (rsp_peak_work),
   .rsp_peak_events         (rsp_peak_events),
   .rsp_work_peak_expired   (rsp_work_peak_expired),
   .rsp_events_peak_expired (rsp_events_peak_expired)
);

`default_nettype wire
